@@ rtl/kmd_pkg.sv @@
// Package for the key matrix debouncer with its event queue.
// Holds parameter defaults, the item operation codes and code widths.
// No dependencies; every other file of the block imports it.
`default_nettype none

package kmd_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned MATRIX_BITS_DEF   = 64;

  localparam int unsigned PORT_BITS = 64;
  localparam int unsigned CODE_W    = 8;

  localparam logic [CODE_W-1:0] NONE_CODE_RST = 8'hFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

endpackage

`default_nettype wire

@@ rtl/kmd_front.sv @@
// Front end: accepts items, keeps the sample history and classifies key edges.
// Depends on kmd_pkg; feeds the command queue.
`default_nettype none

module kmd_front import kmd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MATRIX_BITS   = MATRIX_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_push_i,
  input  wire logic                   operation_i,
  input  wire logic [MATRIX_BITS-1:0] sample_i,
  input  wire logic                   cmd_full_i,
  output logic                        cmd_push_o,
  output op_e                         cmd_op_o,
  output logic [MATRIX_BITS-1:0]      cmd_edges_o,
  output logic [MATRIX_BITS-1:0]      cmd_held_o
);

  logic                   accept;
  logic                   take_sample;
  logic [MATRIX_BITS-1:0] held;
  logic [MATRIX_BITS-1:0] prev_held_q;

  assign accept      = in_push_i && !cmd_full_i;
  assign take_sample = accept && (op_e'(operation_i) == OP_SAMPLE);

  // A key is held only when the newest sample and every stored one show it.
  if (HISTORY_DEPTH > 1) begin : g_hist
    logic [MATRIX_BITS-1:0] hist_q [HISTORY_DEPTH-1];

    always_comb begin
      held = sample_i;
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        held = held & hist_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
          hist_q[k] <= '0;
        end
      end else if (take_sample) begin
        hist_q[0] <= sample_i;
        for (int k = 1; k < HISTORY_DEPTH - 1; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
      end
    end
  end else begin : g_nohist
    assign held = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_held_q <= '0;
    end else if (take_sample) begin
      prev_held_q <= held;
    end
  end

  assign cmd_push_o  = accept;
  assign cmd_op_o    = op_e'(operation_i);
  assign cmd_edges_o = held ^ prev_held_q;
  assign cmd_held_o  = held;

endmodule

`default_nettype wire

@@ rtl/kmd_cmdq.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on kmd_pkg for its default width, taken from MATRIX_BITS_DEF.
`default_nettype none

module kmd_cmdq import kmd_pkg::*; #(
  parameter int unsigned WIDTH = 2 * MATRIX_BITS_DEF + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/kmd_back.sv @@
// Back end: scans key edges into the event ring, serves reads, holds the result.
// Depends on kmd_pkg; takes commands from kmd_cmdq.
`default_nettype none

module kmd_back import kmd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned MATRIX_BITS = MATRIX_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire op_e                    cmd_op_i,
  input  wire logic [MATRIX_BITS-1:0] cmd_edges_i,
  input  wire logic [MATRIX_BITS-1:0] cmd_held_i,
  output logic                        cmd_pop_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CODE_W-1:0]      cfg_wdata_i,
  input  wire logic                   pop_i,
  output logic                        empty_o,
  output logic [CODE_W-1:0]           key_code_o,
  output logic                        key_valid_o,
  output logic [MATRIX_BITS-1:0]      debounced_keys_o,
  output logic                        events_dropped_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned BitW = $clog2(MATRIX_BITS);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [BitW-1:0] BitLast = BitW'(MATRIX_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_RESULT
  } state_e;

  state_e                 state_q;
  logic [BitW-1:0]        bit_q;
  logic [IdxW-1:0]        wr_q;
  logic [IdxW-1:0]        rd_q;
  logic [IdxW-1:0]        wr_next;
  logic [IdxW-1:0]        rd_next;
  logic                   ring_full;
  logic                   scan_push;
  logic                   out_load;
  logic [CODE_W-1:0]      none_q;
  logic [MATRIX_BITS-1:0] key_state_q;
  logic [MATRIX_BITS-1:0] edges_q;
  logic [MATRIX_BITS-1:0] held_q;
  logic [CODE_W-1:0]      mem_q [QUEUE_DEPTH];
  logic [CODE_W-1:0]      rdata_q;
  logic [CODE_W-1:0]      res_code_q;
  logic                   res_valid_q;
  logic                   drop_q;
  logic                   out_valid_q;
  logic [CODE_W-1:0]      out_code_q;
  logic                   out_kvalid_q;
  logic                   out_drop_q;
  logic [MATRIX_BITS-1:0] out_keys_q;

  assign wr_next   = (wr_q == IdxLast) ? '0 : wr_q + 1'b1;
  assign rd_next   = (rd_q == IdxLast) ? '0 : rd_q + 1'b1;
  // The ring keeps one slot free, so it is full when the write index would catch up.
  assign ring_full = (wr_next == rd_q);
  assign scan_push = (state_q == ST_SCAN) && edges_q[bit_q] && !ring_full;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      edges_q <= cmd_edges_i;
      held_q  <= cmd_held_i;
    end
  end

  // A press queues the key index, a release queues the none code.
  always_ff @(posedge clk_i) begin
    if (scan_push) begin
      mem_q[wr_q] <= held_q[bit_q] ? CODE_W'(bit_q) : none_q;
    end
    rdata_q <= mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_q        <= '0;
      wr_q         <= '0;
      rd_q         <= '0;
      none_q       <= NONE_CODE_RST;
      key_state_q  <= '0;
      res_code_q   <= '0;
      res_valid_q  <= 1'b0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_code_q   <= '0;
      out_kvalid_q <= 1'b0;
      out_drop_q   <= 1'b0;
      out_keys_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        none_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            drop_q <= 1'b0;
            if (cmd_op_i == OP_SAMPLE) begin
              bit_q   <= '0;
              state_q <= ST_SCAN;
            end else if (rd_q != wr_q) begin
              state_q <= ST_RDWAIT;
            end else begin
              res_code_q  <= none_q;
              res_valid_q <= 1'b0;
              state_q     <= ST_RESULT;
            end
          end
        end
        ST_SCAN: begin
          if (edges_q[bit_q]) begin
            if (ring_full) begin
              drop_q <= 1'b1;
            end else begin
              wr_q <= wr_next;
            end
          end
          if (bit_q == BitLast) begin
            key_state_q <= held_q;
            res_code_q  <= none_q;
            res_valid_q <= 1'b0;
            state_q     <= ST_RESULT;
          end else begin
            bit_q <= bit_q + 1'b1;
          end
        end
        ST_RDWAIT: begin
          res_code_q  <= rdata_q;
          res_valid_q <= 1'b1;
          rd_q        <= rd_next;
          state_q     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            out_code_q   <= res_code_q;
            out_kvalid_q <= res_valid_q;
            out_drop_q   <= drop_q;
            out_keys_q   <= key_state_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty_o          = !out_valid_q;
  assign key_code_o       = out_code_q;
  assign key_valid_o      = out_kvalid_q;
  assign debounced_keys_o = out_keys_q;
  assign events_dropped_o = out_drop_q;

`ifndef SYNTHESIS
  a_rdwait_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |-> (rd_q != wr_q))
    else $error("read issued on an empty event ring");

  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(wr_q) < QUEUE_DEPTH) && (int'(rd_q) < QUEUE_DEPTH))
    else $error("event ring index out of range");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && (bit_q == BitLast) |=> (state_q == ST_RESULT))
    else $error("edge scan did not finish after the last key");

  a_pop_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_drop_q |-> !out_kvalid_q)
    else $error("result both popped a code and flagged a dropped event");
`endif

endmodule

`default_nettype wire

@@ rtl/key_matrix_debounce_event_fifo.sv @@
// Key matrix debouncer with a key event queue. A sample item (operation 0) is
// taken by the front end, which ANDs it with the stored history and marks the
// keys whose held state changed; a two-entry command queue then lets the front
// end take the next item while the back end works. The back end scans the key
// bits one per cycle and queues the changed ones into the event ring. A read
// item (operation 1) passes through a wait state because the ring is a memory
// with a registered read port, and goes straight to the result when the ring
// is empty. The back end finishes one item before it takes the next. Results
// wait in an output register until popped. No clearing pass is needed after
// reset.
`default_nettype none

module key_matrix_debounce_event_fifo import kmd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned MATRIX_BITS   = MATRIX_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 operation_i,
  input  wire logic [PORT_BITS-1:0] sample_matrix_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [CODE_W-1:0]         key_code_o,
  output logic                      key_valid_o,
  output logic [PORT_BITS-1:0]      debounced_keys_o,
  output logic                      events_dropped_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CODE_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CmdW = 2 * MATRIX_BITS + 1;

  logic                   f_push;
  op_e                    f_op;
  logic [MATRIX_BITS-1:0] f_edges;
  logic [MATRIX_BITS-1:0] f_held;
  logic [CmdW-1:0]        q_data;
  logic                   q_valid;
  logic                   q_pop;
  logic [MATRIX_BITS-1:0] b_keys;

  kmd_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MATRIX_BITS  (MATRIX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_push_i  (push),
    .operation_i(operation_i),
    .sample_i   (sample_matrix_i[MATRIX_BITS-1:0]),
    .cmd_full_i (full),
    .cmd_push_o (f_push),
    .cmd_op_o   (f_op),
    .cmd_edges_o(f_edges),
    .cmd_held_o (f_held)
  );

  kmd_cmdq #(
    .WIDTH(CmdW)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .data_i ({f_op, f_edges, f_held}),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  kmd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MATRIX_BITS(MATRIX_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_op_i        (op_e'(q_data[CmdW-1])),
    .cmd_edges_i     (q_data[CmdW-2:MATRIX_BITS]),
    .cmd_held_i      (q_data[MATRIX_BITS-1:0]),
    .cmd_pop_o       (q_pop),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pop_i           (pop),
    .empty_o         (empty),
    .key_code_o      (key_code_o),
    .key_valid_o     (key_valid_o),
    .debounced_keys_o(b_keys),
    .events_dropped_o(events_dropped_o)
  );

  assign debounced_keys_o = PORT_BITS'(b_keys);

endmodule

`default_nettype wire

@@ bench/key_matrix_debounce_event_fifo_tb.sv @@
// Self-checking testbench for key_matrix_debounce_event_fifo.
// Depends on kmd_pkg and the block's RTL; a built-in debounce and event-queue
// predictor supplies the expected result of every accepted item.
`timescale 1ns / 100ps

module key_matrix_debounce_event_fifo_tb;
  import kmd_pkg::*;

  localparam int HIST_LEN = int'(HISTORY_DEPTH_DEF);
  localparam int FIFO_ROOM = int'(QUEUE_DEPTH_DEF) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 30;
  localparam int STALL_PCT = 31;

  typedef struct {
    logic [CODE_W-1:0]    code;
    logic                 valid;
    logic [PORT_BITS-1:0] keys;
    logic                 dropped;
  } key_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  op_e                  operation = OP_SAMPLE;
  logic [PORT_BITS-1:0] sample_matrix = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [CODE_W-1:0]    key_code;
  logic                 key_valid;
  logic [PORT_BITS-1:0] debounced_keys;
  logic                 events_dropped;
  logic                 cfg_we = 1'b0;
  logic [CODE_W-1:0]    cfg_wdata = '0;

  // Predictor state.
  logic [PORT_BITS-1:0] scan_hist [HIST_LEN-1];
  logic [PORT_BITS-1:0] held_prev;
  logic [PORT_BITS-1:0] keys_now;
  logic [CODE_W-1:0]    code_fifo [$];
  logic [CODE_W-1:0]    none_code_reg;

  key_result_t expected_results [$];
  bit          stall_en = 1'b1;
  int          errors = 0;
  int          cycle_count = 0;
  int          sample_count = 0;
  int          read_count = 0;
  int          popped_count = 0;
  int          press_count = 0;
  int          drop_count = 0;
  int          results_seen = 0;

  key_matrix_debounce_event_fifo dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .operation_i      (operation),
    .sample_matrix_i  (sample_matrix),
    .empty            (empty),
    .pop              (pop),
    .key_code_o       (key_code),
    .key_valid_o      (key_valid),
    .debounced_keys_o (debounced_keys),
    .events_dropped_o (events_dropped),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PORT_BITS-1:0] rand_matrix();
    return {$urandom, $urandom};
  endfunction

  // Advances the predictor by one item and returns the result it must give.
  function automatic key_result_t debounce_step(op_e op, logic [PORT_BITS-1:0] mat);
    key_result_t res;
    logic [PORT_BITS-1:0] held;
    logic [PORT_BITS-1:0] press;
    logic [PORT_BITS-1:0] rel_mask;
    res.code = none_code_reg;
    res.valid = 1'b0;
    res.dropped = 1'b0;
    if (op == OP_SAMPLE) begin
      held = mat;
      for (int k = 0; k < HIST_LEN - 1; k++) held &= scan_hist[k];
      for (int k = HIST_LEN - 2; k > 0; k--) scan_hist[k] = scan_hist[k-1];
      scan_hist[0] = mat;
      press = held & ~held_prev;
      rel_mask = ~held & held_prev;
      held_prev = held;
      // Edges are queued in bit order; a full queue drops the code.
      for (int b = 0; b < PORT_BITS; b++) begin
        if (press[b]) begin
          if (code_fifo.size() < FIFO_ROOM) code_fifo.push_back(CODE_W'(b));
          else res.dropped = 1'b1;
        end
        if (rel_mask[b]) begin
          if (code_fifo.size() < FIFO_ROOM) code_fifo.push_back(none_code_reg);
          else res.dropped = 1'b1;
        end
      end
      keys_now = (keys_now | press) & ~rel_mask;
      sample_count++;
      press_count += $countones(press);
      if (res.dropped) drop_count++;
    end else begin
      read_count++;
      if (code_fifo.size() > 0) begin
        res.code = code_fifo.pop_front();
        res.valid = 1'b1;
        popped_count++;
      end
    end
    res.keys = keys_now;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with push still high, so consecutive items can go back to back.
  task automatic send_item(op_e op, logic [PORT_BITS-1:0] mat);
    while (stall_en && $urandom_range(99) < STALL_PCT) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    operation <= op;
    sample_matrix <= mat;
    do @(posedge clk_i); while (full);
    expected_results.push_back(debounce_step(op, mat));
    @(negedge clk_i);
  endtask

  // The register is only written once every outstanding result has come back.
  task automatic write_none_code(logic [CODE_W-1:0] value);
    push <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    none_code_reg = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_read();
    send_item(OP_READ, rand_matrix());
  endtask

  // All keys pressed at once overflow the queue, then all released at once
  // find it still full; the reads drain it and end on an empty read.
  task automatic test_queue_overflow();
    repeat (HIST_LEN) send_item(OP_SAMPLE, '1);
    send_item(OP_SAMPLE, '0);
    repeat (FIFO_ROOM + 1) send_item(OP_READ, '1);
  endtask

  // A changed release code must show up both in the queue and on empty reads.
  task automatic test_release_code();
    write_none_code('0);
    repeat (HIST_LEN) send_item(OP_SAMPLE, {1'b1, {(PORT_BITS-1){1'b0}}});
    send_item(OP_SAMPLE, '0);
    repeat (3) send_item(OP_READ, rand_matrix());
  endtask

  // Reads and, among the samples, mostly a slowly changing set of held keys with
  // contact bounce, plus raw noise, full-matrix extremes and occasional mass flips that overflow.
  task automatic test_random(int count, bit stall, logic [CODE_W-1:0] code);
    logic [PORT_BITS-1:0] key_pattern;
    logic [PORT_BITS-1:0] mat;
    int r;
    key_pattern = rand_matrix() & rand_matrix() & rand_matrix();
    write_none_code(code);
    stall_en = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_item(OP_READ, rand_matrix());
      end else begin
        if (r < 51) begin
          mat = rand_matrix();
        end else if (r < 53) begin
          mat = r[0] ? '1 : '0;
        end else if (r < 55) begin
          key_pattern = ~key_pattern;
          mat = key_pattern;
        end else begin
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) key_pattern[$urandom_range(PORT_BITS-1)] ^= 1'b1;
          end
          mat = key_pattern;
          if ($urandom_range(3) == 0) mat[$urandom_range(PORT_BITS-1)] ^= 1'b1;
        end
        send_item(OP_SAMPLE, mat);
      end
    end
    stall_en = 1'b1;
  endtask

  task automatic check_field(string name, logic [PORT_BITS-1:0] want,
                             logic [PORT_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      pop <= !stall_en || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk_i) begin
    key_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected item, expected none, actual code %0h", $time, key_code);
      end else begin
        want = expected_results.pop_front();
        check_field("key_code", want.code, key_code);
        check_field("key_valid", want.valid, key_valid);
        check_field("debounced_keys", want.keys, debounced_keys);
        check_field("events_dropped", want.dropped, events_dropped);
        results_seen++;
      end
    end
  end

  initial begin
    foreach (scan_hist[k]) scan_hist[k] = '0;
    held_prev = '0;
    keys_now = '0;
    none_code_reg = NONE_CODE_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_read();
    test_queue_overflow();
    test_release_code();
    test_random(560, 1'b1, CODE_W'($urandom_range(1, 254)));
    test_random(560, 1'b0, '1);
    test_random(560, 1'b1, CODE_W'($urandom_range(0, 255)));

    push <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results: %0d samples, %0d reads, %0d codes popped.",
             results_seen, sample_count, read_count, popped_count);
    $display("Debounced %0d key presses; %0d samples overflowed the event queue.",
             press_count, drop_count);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
